### design/hopfield_store_and_stability_check_top_defines.svh
// ----------------------------------------------------------------------------
// Hopfield store and stability check: assertion macros
// Shared property shorthands for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HOPFIELD_STORE_AND_STABILITY_CHECK_TOP_DEFINES_SVH
`define HOPFIELD_STORE_AND_STABILITY_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsc assertion failed");

// Next-cycle implication, disabled during reset.
`define HSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsc assertion failed");

`endif

### design/hsc_pkg.sv
// ----------------------------------------------------------------------------
// Hopfield store and stability check package
// Shared constants and the cell control bundle.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int NEURONS_DEF      = 128;
  localparam int MAX_PATTERNS_DEF = 64;
  localparam int W_W              = 8;
  localparam int CFG_W            = 8;
  localparam int IDX_W            = 6;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 8'd100;

  typedef struct packed {
    logic load;    // neuron value transaction being written into the row
    logic in_bit;  // the neuron value itself
    logic clr;     // clear accumulators before a recall pass
    logic acc_en;  // a weight row is present on the chain this cycle
    logic x_r;     // pattern bit of that row
    logic chk;     // stability token moves one cell along
  } cell_ctrl_t;

endpackage

### design/hsc_wmem.sv
// ----------------------------------------------------------------------------
// Weight row memory
// One weight row per entry, registered read, per-row valid bits so that a
// row never written since reset or restart reads as zero.
// ----------------------------------------------------------------------------
module hsc_wmem import hsc_pkg::*; #(
  parameter int NEURONS = NEURONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         re,
  input  logic [$clog2(NEURONS)-1:0]   raddr,
  output logic [NEURONS*W_W-1:0]       rdata,
  input  logic                         we,
  input  logic [$clog2(NEURONS)-1:0]   waddr,
  input  logic [NEURONS*W_W-1:0]       wdata
);

  logic [NEURONS*W_W-1:0] mem [NEURONS];
  logic [NEURONS*W_W-1:0] rd_q;
  logic [NEURONS-1:0]     vld;
  logic                   vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        vld_q <= vld[raddr];
      end
    end
  end

  assign rdata = vld_q ? rd_q : '0;

endmodule

### design/hsc_cell.sv
// ----------------------------------------------------------------------------
// Neuron cell
// Holds one neuron's pattern bit and recall sum, updates its column of the
// weight row passing through, and forwards the stability token.
// ----------------------------------------------------------------------------
module hsc_cell import hsc_pkg::*; #(
  parameter int NEURONS      = NEURONS_DEF,
  parameter int MAX_PATTERNS = MAX_PATTERNS_DEF,
  parameter int ID           = 0
) (
  input  logic                          clk,
  input  cell_ctrl_t                    ctrl,
  input  logic [$clog2(NEURONS+1)-1:0]  load_idx,
  input  logic [$clog2(NEURONS+1)-1:0]  n_eff,
  input  logic [$clog2(NEURONS)-1:0]    row,
  input  logic signed [W_W-1:0]         w_old,
  output logic signed [W_W-1:0]         w_new,
  input  logic                          ok_in,
  output logic                          ok_q,
  output logic                          x
);

  localparam int CNT_W = $clog2(NEURONS + 1);
  localparam int ROW_W = $clog2(NEURONS);
  localparam int ACC_W = $clog2(NEURONS * MAX_PATTERNS + 1) + 1;

  logic                    in_rng;
  logic                    upd;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] w_ext;
  logic                    good;

  assign in_rng = CNT_W'(ID) < n_eff;
  assign upd    = in_rng && (row != ROW_W'(ID));
  assign w_new  = !upd ? w_old :
                  (ctrl.x_r == x) ? w_old + W_W'(1) : w_old - W_W'(1);
  assign w_ext  = ACC_W'(w_new);
  assign good   = !in_rng || ((!acc[ACC_W-1]) == x);

  always_ff @(posedge clk) begin
    if (ctrl.load && load_idx == CNT_W'(ID)) begin
      x <= ctrl.in_bit;
    end
    if (ctrl.clr) begin
      acc <= '0;
    end else if (ctrl.acc_en && in_rng) begin
      acc <= ctrl.x_r ? acc + w_ext : acc - w_ext;
    end
    if (ctrl.chk) begin
      ok_q <= ok_in && good;
    end
  end

endmodule

### design/hopfield_store_and_stability_check_top.sv
// ----------------------------------------------------------------------------
// Hopfield store and stability check, top level
// Handshake: a neuron transaction is accepted when start is high and busy
//   low; the one that completes a pattern has its result reported after the
//   row and token passes, or in the next cycle when the store is full.
// Throughput: one weight row per cycle through the cell chain, then a
//   token pass along all NEURONS cells; busy stays high for that whole time.
// Reset: synchronous, clears all weights, counts and restores active_neurons
//   to 100.
// ----------------------------------------------------------------------------
module hopfield_store_and_stability_check_top import hsc_pkg::*; #(
  parameter int NEURONS      = NEURONS_DEF,
  parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             active_neurons_we,
  input  logic [CFG_W-1:0] active_neurons,
  input  logic             start,
  output logic             busy,
  input  logic             kind,
  input  logic             neuron_value,
  output logic             done,
  output logic [IDX_W-1:0] pattern_index,
  output logic             stable,
  output logic             rejected
);

  // Widths that follow from the array size and the pattern limit.
  localparam int CNT_W = $clog2(NEURONS + 1);
  localparam int ROW_W = $clog2(NEURONS);
  localparam int PAT_W = $clog2(MAX_PATTERNS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W + 1 : CFG_W + 1;

  typedef enum logic [1:0] {S_LOAD, S_RUN, S_CHECK, S_DONE} state_t;

  state_t             state;
  logic [CFG_W-1:0]   an;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   ra;
  logic [CNT_W-1:0]   ck;
  logic [PAT_W-1:0]   stored;
  logic               pv;
  logic [ROW_W-1:0]   prow;

  logic [CMP_W-1:0]   an_ext;
  logic [CNT_W-1:0]   n_cur;
  logic               accept;
  logic               rd_en;
  logic               wclr;
  cell_ctrl_t         ctrl;
  logic [NEURONS*W_W-1:0] rdata;
  logic [NEURONS*W_W-1:0] wdata;
  logic [NEURONS-1:0] xs;
  logic [NEURONS:0]   ok;

  // The neuron count in force is the register clamped into 2..NEURONS.
  always_comb begin
    an_ext = CMP_W'(an);
    if (an_ext < CMP_W'(2)) begin
      an_ext = CMP_W'(2);
    end else if (an_ext > CMP_W'(NEURONS)) begin
      an_ext = CMP_W'(NEURONS);
    end
    n_cur = CNT_W'(an_ext);
  end

  assign busy   = (state != S_LOAD);
  assign accept = start && !busy;
  assign rd_en  = (state == S_RUN) && (ra < n_eff);
  // A restart transaction drops every weight row at once via the valid bits.
  assign wclr   = accept && kind;

  assign ctrl.load   = accept && !kind;
  assign ctrl.in_bit = neuron_value;
  assign ctrl.clr    = (state == S_LOAD);
  assign ctrl.acc_en = pv;
  assign ctrl.x_r    = xs[prow];
  assign ctrl.chk    = (state == S_CHECK);

  // The token enters the first cell already true; each cell registers the
  // token from its neighbour anded with its own verdict.
  assign ok[0] = 1'b1;

  hsc_wmem #(.NEURONS(NEURONS)) u_wmem (
    .clk   (clk),
    .rst   (rst),
    .clr   (wclr),
    .re    (rd_en),
    .raddr (ra[ROW_W-1:0]),
    .rdata (rdata),
    .we    (pv),
    .waddr (prow),
    .wdata (wdata)
  );

  for (genvar i = 0; i < NEURONS; i++) begin : g_cell
    hsc_cell #(
      .NEURONS      (NEURONS),
      .MAX_PATTERNS (MAX_PATTERNS),
      .ID           (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_idx (cnt),
      .n_eff    (n_eff),
      .row      (prow),
      .w_old    (rdata[i*W_W +: W_W]),
      .w_new    (wdata[i*W_W +: W_W]),
      .ok_in    (ok[i]),
      .ok_q     (ok[i+1]),
      .x        (xs[i])
    );
  end

  // Sequencer. Each weight row is read, updated column by column in the
  // cells, written back and, being symmetric, added into the recall sums in
  // the same pass. The stability token then walks the whole chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      an     <= ACTIVE_RESET;
      cnt    <= '0;
      stored <= '0;
      pv     <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      pv   <= rd_en;
      prow <= ra[ROW_W-1:0];
      if (active_neurons_we) begin
        an <= active_neurons;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (kind) begin
              cnt    <= '0;
              stored <= '0;
            end else if ((CNT_W+1)'(cnt) + (CNT_W+1)'(1) >= (CNT_W+1)'(n_cur)) begin
              cnt <= '0;
              if (stored >= PAT_W'(MAX_PATTERNS)) begin
                done          <= 1'b1;
                rejected      <= 1'b1;
                stable        <= 1'b0;
                pattern_index <= '0;
              end else begin
                n_eff <= n_cur;
                ra    <= '0;
                state <= S_RUN;
              end
            end else begin
              cnt <= cnt + CNT_W'(1);
            end
          end
        end
        S_RUN: begin
          if (ra < n_eff) begin
            ra <= ra + CNT_W'(1);
          end else if (!pv) begin
            ck    <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          ck <= ck + CNT_W'(1);
          if (ck == CNT_W'(NEURONS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done          <= 1'b1;
          stable        <= ok[NEURONS];
          rejected      <= 1'b0;
          pattern_index <= IDX_W'(stored);
          stored        <= stored + PAT_W'(1);
          state         <= S_LOAD;
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

### design/hsc_checker.sv
// ----------------------------------------------------------------------------
// Hopfield store and stability check, port checker
// Watches the top level's ports and is bound to it below.
// ----------------------------------------------------------------------------
`include "hopfield_store_and_stability_check_top_defines.svh"

module hsc_port_checker import hsc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             kind,
  input logic             done,
  input logic [IDX_W-1:0] pattern_index,
  input logic             stable,
  input logic             rejected
);

  `HSC_ASSERT_IMP(a_rej_clean, clk, rst, done && rejected, !stable && pattern_index == '0)
  `HSC_ASSERT_NXT(a_single, clk, rst, done, !done)
  `HSC_ASSERT_IMP(a_busy_cause, clk, rst, $rose(busy), $past(start) && !$past(kind))
  `HSC_ASSERT_NXT(a_restart_quiet, clk, rst, start && !busy && kind, !busy && !done)

endmodule

bind hopfield_store_and_stability_check_top hsc_port_checker u_hsc_port_checker (.*);

### dv/hsc_checker.sv
// ----------------------------------------------------------------------------
// Hopfield store and stability checker
// Watches the command and result ports, keeps its own weight matrix and
// pattern buffer, predicts each completed pattern's outcome and compares.
// ----------------------------------------------------------------------------
module hsc_checker import hsc_pkg::*; #(
  parameter int NEURONS      = NEURONS_DEF,
  parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             active_neurons_we,
  input  logic [CFG_W-1:0] active_neurons,
  input  logic             start,
  input  logic             busy,
  input  logic             kind,
  input  logic             neuron_value,
  input  logic             done,
  input  logic [IDX_W-1:0] pattern_index,
  input  logic             stable,
  input  logic             rejected,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             stab;
    logic             rej;
  } outcome_t;

  outcome_t         outcomes_due[$];
  int               weights[NEURONS][NEURONS];
  logic             pat_bits[NEURONS];
  int               fill_count;
  int               stored_count;
  logic [CFG_W-1:0] neuron_count_reg;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int bip(input logic b);
    return b ? 1 : -1;
  endfunction

  task automatic store_pattern(input int n);
    outcome_t o;
    int       acc;
    logic     ok;
    if (stored_count >= MAX_PATTERNS) begin
      o = '{idx: '0, stab: 1'b0, rej: 1'b1};
    end else begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (i != j) weights[i][j] += bip(pat_bits[i]) * bip(pat_bits[j]);
      ok = 1'b1;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++) acc += weights[i][j] * bip(pat_bits[j]);
        if ((acc >= 0) != pat_bits[i]) ok = 1'b0;
      end
      o = '{idx: stored_count[IDX_W-1:0], stab: ok, rej: 1'b0};
      stored_count++;
    end
    outcomes_due.push_back(o);
  endtask

  always @(posedge clk) begin
    int       n;
    outcome_t e;
    if (rst) begin
      foreach (weights[i, j]) weights[i][j] = 0;
      fill_count       = 0;
      stored_count     = 0;
      neuron_count_reg = ACTIVE_RESET;
    end else begin
      if (done) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = outcomes_due.pop_front();
          if (pattern_index !== e.idx)
            report_mismatch($sformatf("pattern_index %0d, expected %0d",
                                      pattern_index, e.idx));
          if (stable !== e.stab)
            report_mismatch($sformatf("stable %0b, expected %0b", stable, e.stab));
          if (rejected !== e.rej)
            report_mismatch($sformatf("rejected %0b, expected %0b",
                                      rejected, e.rej));
        end
      end
      if (start && !busy) begin
        if (kind) begin
          foreach (weights[i, j]) weights[i][j] = 0;
          stored_count = 0;
          fill_count   = 0;
        end else begin
          n = neuron_count_reg;
          if (n < 2) n = 2;
          if (n > NEURONS) n = NEURONS;
          if (fill_count < NEURONS) pat_bits[fill_count] = neuron_value;
          fill_count++;
          if (fill_count >= n) begin
            fill_count = 0;
            store_pattern(n);
          end
        end
      end
      if (active_neurons_we) neuron_count_reg = active_neurons;
    end
    pending = outcomes_due.size();
  end
endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// Hopfield store and stability check testbench
// Drives neuron and restart transactions in phases of differing neuron
// counts, with random gaps, while the checker predicts every result.
// ----------------------------------------------------------------------------
module tb;
  import hsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEURONS = NEURONS_DEF;
  // Longest time a pattern result can take after its last transaction.
  localparam int DRAIN_CYCLES = 2 * NEURONS + 20;

  logic             clk;
  logic             rst;
  logic             active_neurons_we;
  logic [CFG_W-1:0] active_neurons;
  logic             start;
  logic             busy;
  logic             kind;
  logic             neuron_value;
  logic             done;
  logic [IDX_W-1:0] pattern_index;
  logic             stable;
  logic             rejected;
  int               fail_count;
  int               pending;
  // When set, the sender never idles; set at random for about one phase in six.
  bit               no_gaps;

  hopfield_store_and_stability_check_top DUT (
    .clk(clk), .rst(rst),
    .active_neurons_we(active_neurons_we), .active_neurons(active_neurons),
    .start(start), .busy(busy), .kind(kind), .neuron_value(neuron_value),
    .done(done), .pattern_index(pattern_index), .stable(stable),
    .rejected(rejected)
  );

  hsc_checker u_checker (
    .clk(clk), .rst(rst),
    .active_neurons_we(active_neurons_we), .active_neurons(active_neurons),
    .start(start), .busy(busy), .kind(kind), .neuron_value(neuron_value),
    .done(done), .pattern_index(pattern_index), .stable(stable),
    .rejected(rejected), .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Sends one transaction; called just after a rising edge. A random gap may
  // come first; start then stays high until the block accepts it, and the
  // task returns at the accepting edge so the next one can follow directly.
  task automatic send_txn(input logic k, input logic v);
    if (!no_gaps) begin
      while ($urandom_range(99) < 20) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start        <= 1'b1;
    kind         <= k;
    neuron_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Waits until every expected result has arrived, then lets the block
  // settle before anything else touches its register.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input logic [CFG_W-1:0] n);
    drain();
    @(posedge clk);
    active_neurons_we <= 1'b1;
    active_neurons    <= n;
    @(posedge clk);
    active_neurons_we <= 1'b0;
  endtask

  // Sends one whole pattern of n neurons; mode picks all +1, all -1,
  // alternating or random content.
  task automatic send_pattern(input int n, input int mode);
    for (int i = 0; i < n; i++)
      case (mode)
        0: send_txn(1'b0, 1'b1);
        1: send_txn(1'b0, 1'b0);
        2: send_txn(1'b0, i[0]);
        default: send_txn(1'b0, 1'($urandom_range(1)));
      endcase
  endtask

  initial begin
    int sent;
    int n;
    rst               = 1'b1;
    start             = 1'b0;
    kind              = 1'b0;
    neuron_value      = 1'b0;
    active_neurons_we = 1'b0;
    active_neurons    = '0;
    no_gaps           = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: the smallest count, including a count below the
    // legal range, then a restart in the middle of a pattern.
    set_count(8'd0);
    send_pattern(2, 0);
    send_pattern(2, 2);
    send_txn(1'b0, 1'b1);
    send_txn(1'b1, 1'b0);
    set_count(8'd3);
    send_pattern(3, 1);
    send_pattern(3, 3);
    // A count above NEURONS acts as NEURONS; one full-size pattern.
    set_count(8'd255);
    send_pattern(NEURONS, 3);
    send_txn(1'b1, 1'b1);
    // Count changed mid pattern: the pattern completes at once.
    set_count(8'd6);
    send_txn(1'b0, 1'b1);
    send_txn(1'b0, 1'b0);
    send_txn(1'b0, 1'b1);
    set_count(8'd2);
    send_txn(1'b0, 1'b0);
    drain();
    // Fill the store beyond its capacity so that rejection is exercised.
    for (int p = 0; p < 68; p++) send_pattern(2, 3);
    send_txn(1'b1, 1'b0);

    // Random part: small counts mostly, a few wider ones; rare restarts.
    sent = 0;
    while (sent < 570) begin
      case ($urandom_range(9))
        0: n = NEURONS;
        1, 2: n = $urandom_range(9, 24);
        default: n = $urandom_range(2, 8);
      endcase
      set_count(n[CFG_W-1:0]);
      no_gaps = ($urandom_range(5) == 0);
      for (int p = 0; p < $urandom_range(3, 12) && sent < 570; p++) begin
        if ($urandom_range(19) == 0) begin
          send_txn(1'b1, 1'($urandom_range(1)));
          sent++;
        end
        send_pattern(n, $urandom_range(9) < 2 ? $urandom_range(2) : 3);
        sent += n;
      end
      no_gaps = 1'b0;
    end
    set_count(8'd100);
    send_pattern(100, 3);

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule
